/* rtl/core/sor_stencil_sweep_top_defines.svh */
// ----------------------------------------------------------------------------
// SOR stencil sweep assertion macros
// Shared property forms for the checker of the sweep block.
// ----------------------------------------------------------------------------
`ifndef SOR_STENCIL_SWEEP_TOP_DEFINES_SVH
`define SOR_STENCIL_SWEEP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SOR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SOR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sor_pkg.sv */
// ----------------------------------------------------------------------------
// SOR stencil sweep package
// Widths, register indexes and payload types shared across the block.
// ----------------------------------------------------------------------------
package sor_pkg;

    localparam int DATA_W     = 32;
    localparam int NORM_W     = 63;
    localparam int SIZE_W     = 11;
    localparam int OMEGA_W    = 18;
    localparam int OMEGA_FRAC = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    typedef logic signed [DATA_W-1:0] value_t;
    typedef logic [NORM_W-1:0]        norm_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
    typedef logic [SIZE_W-1:0]        size_t;
    typedef logic [OMEGA_W-1:0]       omega_t;

    // register indexes
    localparam cfg_idx_t CFG_COLUMNS = 2'd0;
    localparam cfg_idx_t CFG_ROWS    = 2'd1;
    localparam cfg_idx_t CFG_OMEGA   = 2'd2;

    // reset values
    localparam size_t  COLUMNS_RST = 11'd1024;
    localparam size_t  ROWS_RST    = 11'd1024;
    localparam omega_t OMEGA_RST   = 18'd130671;

endpackage

/* rtl/core/sor_if.sv */
// ----------------------------------------------------------------------------
// SOR stencil sweep channels
// Valid/ready interfaces for stencil items in and relaxed results out.
// ----------------------------------------------------------------------------
interface sor_in_if
    import sor_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t center_old;
    value_t east_old;
    value_t south_old;
    value_t west_ghost;
    value_t north_ghost;

    modport source (output valid, center_old, east_old, south_old, west_ghost,
                    north_ghost, input ready);
    modport sink   (input valid, center_old, east_old, south_old, west_ghost,
                    north_ghost, output ready);
endinterface

interface sor_out_if
    import sor_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t new_value;
    norm_t  sweep_norm;
    logic   sweep_last;

    modport source (output valid, new_value, sweep_norm, sweep_last, input ready);
    modport sink   (input valid, new_value, sweep_norm, sweep_last, output ready);
endinterface

/* rtl/core/sor_stencil_sweep_top.sv */
// ----------------------------------------------------------------------------
// SOR stencil sweep
// One Gauss-Seidel over-relaxation sweep, raster order, with a line buffer
// of new values and a saturating sum of squared changes.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake        | payload
//  ----------+-----+------------------+-----------------------------------------
//  stencil   | in  | valid / ready    | center_old east_old south_old
//            |     |                  | west_ghost north_ghost
//  result    | out | valid / ready    | new_value sweep_norm sweep_last
//  cfg       | in  | cfg_we (no wait) | cfg_index cfg_data
//
//  Input is refused while stage 1 holds an item, so a new item is not taken
//  before the last one leaves stage 1, and the west-to-east loop (new value
//  feeds the next point) spans stage 1, which forms the neighbor sum, and
//  stage 1b, which does the omega multiply-add and writes west_new and the line buffer.
//  Result path: stage 1, 1b, 2, 3 and 4 registers, then the output register.
//  All stages advance together; a held result stalls the whole pipe and input.
//  Reset clears control, counters, the norm and config; the line buffer needs
//  no clearing pass since row 0 never reads it.
// ----------------------------------------------------------------------------
module sor_stencil_sweep_top
    import sor_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    sor_in_if.sink     stencil,
    sor_out_if.source  result,
    input  logic       cfg_we,
    input  cfg_idx_t   cfg_index,
    input  cfg_data_t  cfg_data
);

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CSZ_W = COL_W + 1;
    localparam int RSZ_W = ROW_W + 1;
    // product widths: centre * (1 - omega) and omega * neighbor sum
    localparam int OMC_W  = OMEGA_W + 1;
    localparam int PC_W   = DATA_W + OMC_W;
    localparam int SUM_W  = DATA_W + 2;
    localparam int PN_W   = OMC_W + SUM_W;
    localparam int ACC_W  = PC_W + 3;
    localparam int SHIFT  = OMEGA_FRAC + 2;
    localparam int DIFF_W = DATA_W + 1;
    localparam int SQ_W   = 2 * DATA_W;

    localparam logic signed [ACC_W-1:0] NV_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] NV_MIN = ACC_W'(-64'sd2147483648);
    localparam logic [SQ_W:0] NORM_SAT = {2'b00, {NORM_W{1'b1}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    size_t  grid_columns_reg;
    size_t  grid_rows_reg;
    omega_t relax_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= COLUMNS_RST;
            grid_rows_reg    <= ROWS_RST;
            relax_factor_reg <= OMEGA_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLUMNS: grid_columns_reg <= cfg_data[SIZE_W-1:0];
                CFG_ROWS:    grid_rows_reg    <= cfg_data[SIZE_W-1:0];
                CFG_OMEGA:   relax_factor_reg <= cfg_data[OMEGA_W-1:0];
                default:     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: one enable for every stage
    // ------------------------------------------------------------------
    logic adv;
    logic accept;
    logic s1_valid_reg;
    logic s1b_valid_reg;

    // a new item waits until stage 1 has moved its item on to stage 1b
    assign adv           = !result.valid || result.ready;
    assign stencil.ready = adv && !s1_valid_reg;
    assign accept        = stencil.valid && adv && !s1_valid_reg;

    // ------------------------------------------------------------------
    // raster counters, sizes clamped to 1..MAX
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [CSZ_W-1:0] cols_eff;
    logic [RSZ_W-1:0] rows_eff;
    logic             last_col, last_row;

    always_comb
    begin
        if (grid_columns_reg == '0)
            cols_eff = CSZ_W'(1);
        else if (32'(grid_columns_reg) > MAX_COLUMNS)
            cols_eff = CSZ_W'(MAX_COLUMNS);
        else
            cols_eff = CSZ_W'(grid_columns_reg);

        if (grid_rows_reg == '0)
            rows_eff = RSZ_W'(1);
        else if (32'(grid_rows_reg) > MAX_ROWS)
            rows_eff = RSZ_W'(MAX_ROWS);
        else
            rows_eff = RSZ_W'(grid_rows_reg);

        last_col = ({1'b0, col_count_reg} + CSZ_W'(1)) >= cols_eff;
        last_row = ({1'b0, row_count_reg} + RSZ_W'(1)) >= rows_eff;

        col_count_next = col_count_reg + COL_W'(1);
        row_count_next = row_count_reg;
        if (last_col)
        begin
            col_count_next = '0;
            row_count_next = last_row ? '0 : row_count_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1 registers: operands, centre product, line buffer read
    // stage 1b registers: neighbor sum and what the multiply-add needs
    // ------------------------------------------------------------------
    value_t                  s1_centre_reg;
    value_t                  s1_east_reg;
    value_t                  s1_south_reg;
    value_t                  s1_wghost_reg;
    value_t                  s1_nghost_reg;
    logic signed [PC_W-1:0]  s1_prod_c_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic                    s1_first_col_reg;
    logic                    s1_first_row_reg;
    logic                    s1_fwd_reg;
    logic                    s1_last_reg;

    value_t                  s1b_centre_reg;
    logic signed [PC_W-1:0]  s1b_prod_c_reg;
    logic signed [SUM_W-1:0] s1b_sum_reg;
    logic [COL_W-1:0]        s1b_col_reg;
    logic                    s1b_last_reg;

    logic signed [OMC_W-1:0] one_minus_omega;
    logic signed [PC_W-1:0]  prod_c_next;
    logic                    fwd_next;

    assign one_minus_omega = OMC_W'(1 << OMEGA_FRAC) - $signed({1'b0, relax_factor_reg});
    assign prod_c_next     = PC_W'(stencil.center_old) * PC_W'(one_minus_omega);
    // stage 1b writes the same entry at the edge this item reads it
    assign fwd_next        = s1b_valid_reg && (s1b_col_reg == col_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s1b_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_centre_reg    <= stencil.center_old;
            s1_east_reg      <= stencil.east_old;
            s1_south_reg     <= stencil.south_old;
            s1_wghost_reg    <= stencil.west_ghost;
            s1_nghost_reg    <= stencil.north_ghost;
            s1_prod_c_reg    <= prod_c_next;
            s1_col_reg       <= col_count_reg;
            s1_first_col_reg <= (col_count_reg == '0);
            s1_first_row_reg <= (row_count_reg == '0);
            s1_fwd_reg       <= fwd_next;
            s1_last_reg      <= last_col && last_row;
        end
    end

    // ------------------------------------------------------------------
    // line buffer: new values of the previous row, one read, one write
    // ------------------------------------------------------------------
    value_t row_mem [MAX_COLUMNS];
    value_t rd_data_reg;
    value_t west_new_reg;
    value_t nv;
    logic   wr_en;

    assign wr_en = adv && s1b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            row_mem[s1b_col_reg] <= nv;
        if (accept)
            rd_data_reg <= row_mem[col_count_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            west_new_reg <= '0;
        else if (wr_en)
            west_new_reg <= nv;
    end

    // ------------------------------------------------------------------
    // stage 1 logic: neighbor sum
    // ------------------------------------------------------------------
    value_t                  west_b, north_b;
    logic signed [SUM_W-1:0] nbr_sum;

    always_comb
    begin
        west_b = s1_first_col_reg ? s1_wghost_reg : west_new_reg;
        if (s1_first_row_reg)
            north_b = s1_nghost_reg;
        else if (s1_fwd_reg)
            north_b = west_new_reg;     // same-edge write forwarded
        else
            north_b = rd_data_reg;

        nbr_sum = SUM_W'(west_b) + SUM_W'(s1_east_reg) + SUM_W'(north_b)
                + SUM_W'(s1_south_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1b_centre_reg <= s1_centre_reg;
            s1b_prod_c_reg <= s1_prod_c_reg;
            s1b_sum_reg    <= nbr_sum;
            s1b_col_reg    <= s1_col_reg;
            s1b_last_reg   <= s1_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1b logic: omega multiply-add, floor, saturate
    // ------------------------------------------------------------------
    logic signed [PN_W-1:0]  prod_n;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] nv_wide;

    always_comb
    begin
        prod_n  = PN_W'($signed({1'b0, relax_factor_reg})) * PN_W'(s1b_sum_reg);
        acc     = (ACC_W'(s1b_prod_c_reg) <<< 2) + ACC_W'(prod_n);
        nv_wide = acc >>> SHIFT;

        if (nv_wide > NV_MAX)
            nv = value_t'(NV_MAX[DATA_W-1:0]);
        else if (nv_wide < NV_MIN)
            nv = value_t'(NV_MIN[DATA_W-1:0]);
        else
            nv = nv_wide[DATA_W-1:0];
    end

    // ------------------------------------------------------------------
    // stages 2..4: change magnitude, square, saturating accumulate
    // ------------------------------------------------------------------
    logic              s2_valid_reg, s3_valid_reg, s4_valid_reg;
    value_t            s2_nv_reg, s3_nv_reg, s4_nv_reg;
    value_t            s2_centre_reg;
    logic              s2_last_reg, s3_last_reg, s4_last_reg;
    logic [DATA_W-1:0] s3_mag_reg;
    logic [SQ_W-1:0]   s4_sq_reg;

    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        mag_wide;

    assign diff     = DIFF_W'(s2_nv_reg) - DIFF_W'(s2_centre_reg);
    assign mag_wide = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1b_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_nv_reg     <= nv;
            s2_centre_reg <= s1b_centre_reg;
            s2_last_reg   <= s1b_last_reg;
            s3_nv_reg     <= s2_nv_reg;
            s3_mag_reg    <= mag_wide[DATA_W-1:0];  // |diff| < 2^32
            s3_last_reg   <= s2_last_reg;
            s4_nv_reg     <= s3_nv_reg;
            s4_sq_reg     <= SQ_W'(s3_mag_reg) * SQ_W'(s3_mag_reg);
            s4_last_reg   <= s3_last_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register and norm accumulator
    // ------------------------------------------------------------------
    logic      out_valid_reg;
    value_t    new_value_reg;
    norm_t     sweep_norm_reg;
    logic      sweep_last_reg;
    norm_t     norm_accum_reg;
    logic [SQ_W:0] norm_sum;
    norm_t     norm_next;

    assign norm_sum  = {2'b00, norm_accum_reg} + {1'b0, s4_sq_reg};
    assign norm_next = (norm_sum > NORM_SAT) ? {NORM_W{1'b1}} : norm_sum[NORM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            norm_accum_reg <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= s4_valid_reg;
            if (s4_valid_reg)
                norm_accum_reg <= s4_last_reg ? '0 : norm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            new_value_reg  <= s4_nv_reg;
            sweep_norm_reg <= s4_last_reg ? norm_next : '0;
            sweep_last_reg <= s4_last_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.new_value  = new_value_reg;
    assign result.sweep_norm = sweep_norm_reg;
    assign result.sweep_last = sweep_last_reg;

endmodule

/* rtl/core/sor_checker.sv */
// ----------------------------------------------------------------------------
// SOR stencil sweep checker
// Port-level properties of the sweep block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sor_stencil_sweep_top_defines.svh"

module sor_checker
    import sor_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input value_t new_value,
    input norm_t  sweep_norm,
    input logic   sweep_last
);

    // held result keeps its valid and value
    `SOR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `SOR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(new_value), "result changed while stalled")
    // norm only shows on the final point
    `SOR_ASSERT_NOW(a_norm_last, out_valid && !sweep_last, sweep_norm == '0, "norm outside last point")
    // input is never taken while a result is stalled
    `SOR_ASSERT_NOW(a_in_ready, in_ready, !out_valid || out_ready, "input ready under output stall")

endmodule

bind sor_stencil_sweep_top sor_checker u_sor_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (stencil.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .new_value  (result.new_value),
    .sweep_norm (result.sweep_norm),
    .sweep_last (result.sweep_last)
);
